FILE: rtl/esm_pkg.sv
`default_nettype none

package esm_pkg;

   // Default depth of the time stamp ring.
   localparam int DEFAULT_RING_DEPTH = 21;

   // Gaps longer than this clear the speed state.
   localparam logic [31:0] IDLE_LIMIT_MS = 32'd1000;

   localparam logic [15:0] SAT16 = 16'hFFFF;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RING_WINDOW     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_SCALE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MM_PER_COUNT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKING_DIVISOR = 3'd4;

   localparam logic [7:0]  RESET_RING_WINDOW     = 8'd3;
   localparam logic [15:0] RESET_TIMEOUT         = 16'd200;
   localparam logic [15:0] RESET_SPEED_SCALE     = 16'd1100;
   localparam logic [7:0]  RESET_MM_PER_COUNT    = 8'd11;
   localparam logic [15:0] RESET_BRAKING_DIVISOR = 16'd70;

   // The divider produces sixteen quotient bits plus one overflow bit.
   localparam int DIV_STEPS  = 17;
   localparam int DIV_STEP_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [31:0] now_ms;
      logic        edge_req;
      logic        clear_counts;
   } req_type;

   typedef struct packed {
      logic        edge_accepted;
      logic [15:0] speed_cm_s;
      logic [15:0] average_speed_cm_s;
      logic        average_full;
      logic [15:0] distance_mm;
      logic [15:0] braking_distance_mm;
      logic [15:0] total_count;
      logic [15:0] ride_count;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/encoder_speed_meter_unit.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  esm_pkg::req_type  (time, edge, clear)
// rsp       out        rsp_valid / rsp_stall  esm_pkg::rsp_type  (speeds, distances, counts)
// csr       in         csr_we                 csr_index, csr_data (five registers)
//
// The block takes no new item until it is back in its idle state. It uses the shared
// divider, which yields one quotient bit per cycle and runs up to three times per item
// (average, speed, braking).
// Reset is synchronous and active high; it restores the register defaults and
// empties the time stamp ring, which needs no clearing pass.
// A stalled result sits in the output register; the next item may already be taken
// and worked on, and it waits in its final state until that register is free.
`default_nettype none

module encoder_speed_meter_unit #(
   parameter int RING_DEPTH = esm_pkg::DEFAULT_RING_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire esm_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output esm_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [esm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [esm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EDGE     = 4'd1;
   localparam logic [3:0] S_RD_A     = 4'd2;
   localparam logic [3:0] S_RD_B     = 4'd3;
   localparam logic [3:0] S_SPAN     = 4'd4;
   localparam logic [3:0] S_AVG      = 4'd5;
   localparam logic [3:0] S_AVG_WAIT = 4'd6;
   localparam logic [3:0] S_SPD      = 4'd7;
   localparam logic [3:0] S_SPD_WAIT = 4'd8;
   localparam logic [3:0] S_SQR      = 4'd9;
   localparam logic [3:0] S_BRK      = 4'd10;
   localparam logic [3:0] S_BRK_WAIT = 4'd11;
   localparam logic [3:0] S_DIST     = 4'd12;
   localparam logic [3:0] S_OUT      = 4'd13;

   logic [3:0]        state_ff, state_in;
   esm_pkg::req_type  item_ff, item_in;

   // Configuration registers.
   logic [7:0]  ring_window_ff, ring_window_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [15:0] speed_scale_ff, speed_scale_in;
   logic [7:0]  mm_per_count_ff, mm_per_count_in;
   logic [15:0] braking_div_ff, braking_div_in;

   // Measurement state.
   logic [31:0]      last_edge_time_ff, last_edge_time_in;
   logic [15:0]      last_interval_ff, last_interval_in;
   logic [IDX_W-1:0] ring_index_ff, ring_index_in;
   logic             ring_full_ff, ring_full_in;
   logic [15:0]      count_total_ff, count_total_in;
   logic [15:0]      count_ride_ff, count_ride_in;
   logic             accepted_ff, accepted_in;

   // Working registers.
   logic [31:0] product_ff, product_in;
   logic [31:0] newest_ff, newest_in;
   logic [31:0] span_ff, span_in;
   logic [15:0] avg_ff, avg_in;
   logic [15:0] speed_ff, speed_in;
   logic [15:0] brake_ff, brake_in;

   logic             rsp_valid_ff, rsp_valid_in;
   esm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Edge handling.
   logic [31:0]      gap;
   logic             edge_ok;
   logic             in_time;
   logic             idle_gap;
   logic [IDX_W-1:0] wr_idx;
   logic             wrap;
   logic [15:0]      total_base, ride_base;

   // Ring reads, multiplier and divider.
   logic [IDX_W-1:0] newest_addr, oldest_addr, rd_addr;
   logic [IDX_W-1:0] avg_factor;
   logic             avg_ok;
   logic [31:0]      rd_data;
   logic [15:0]      mul_a, mul_b;
   logic             out_load;
   logic [15:0]      brake_den;

   esm_pkg::div_req_type div_req;
   esm_pkg::div_rsp_type div_rsp;

   // Gaps are taken modulo 2^32, so a wrapped clock still gives the right gap.
   assign gap      = item_ff.now_ms - last_edge_time_ff;
   assign edge_ok  = item_ff.edge_req && (gap > {24'b0, ring_window_ff});
   assign in_time  = (gap < {16'b0, timeout_ff});
   // An accepted edge makes its own gap zero, so only a quiet item can go idle.
   assign idle_gap = !edge_ok && (gap > esm_pkg::IDLE_LIMIT_MS);
   // A gap at or beyond the timeout restarts the ring at slot zero.
   assign wr_idx   = in_time ? ring_index_ff : '0;
   assign wrap     = (wr_idx == LAST_IDX);

   assign total_base = item_ff.clear_counts ? 16'd0 : count_total_ff;
   assign ride_base  = item_ff.clear_counts ? 16'd0 : count_ride_ff;

   // The newest stamp sits just behind the write pointer. While the ring is
   // still filling the oldest is slot zero; once it has wrapped, the oldest
   // is the slot that the pointer will overwrite next.
   assign newest_addr = (ring_index_ff == '0) ? LAST_IDX : (ring_index_ff - 1'b1);
   assign oldest_addr = ring_full_ff ? ring_index_ff : '0;
   assign rd_addr     = (state_ff == S_RD_B) ? oldest_addr : newest_addr;
   assign avg_factor  = ring_full_ff ? LAST_IDX : (ring_index_ff - 1'b1);

   // A partial ring needs at least two stamps; an idle clear leaves it empty.
   assign avg_ok = (ring_full_ff || ({1'b0, ring_index_ff} >= (IDX_W + 1)'(2)))
                   && (span_ff != 32'd0);

   // A braking divisor of zero behaves as one.
   assign brake_den = (braking_div_ff == 16'd0) ? 16'd1 : braking_div_ff;

   // The single multiplier is shared by the average numerator, the speed
   // square and the distance, each in a state of its own.
   always_comb begin
      case (state_ff)
         S_RD_A: begin
            mul_a = speed_scale_ff;
            mul_b = 16'(avg_factor);
         end
         S_SQR: begin
            mul_a = speed_ff;
            mul_b = speed_ff;
         end
         default: begin
            mul_a = count_ride_ff;
            mul_b = {8'b0, mm_per_count_ff};
         end
      endcase
   end

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in          = state_ff;
      item_in           = item_ff;
      last_edge_time_in = last_edge_time_ff;
      last_interval_in  = last_interval_ff;
      ring_index_in     = ring_index_ff;
      ring_full_in      = ring_full_ff;
      count_total_in    = count_total_ff;
      count_ride_in     = count_ride_ff;
      accepted_in       = accepted_ff;
      product_in        = product_ff;
      newest_in         = newest_ff;
      span_in           = span_ff;
      avg_in            = avg_ff;
      speed_in          = speed_ff;
      brake_in          = brake_ff;
      div_req.start     = 1'b0;
      div_req.num       = product_ff;
      div_req.den       = span_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            // The count clear comes first, then the edge is filtered.
            count_total_in = total_base + 16'(edge_ok);
            count_ride_in  = ride_base + 16'(edge_ok);
            accepted_in    = edge_ok;
            if (edge_ok) begin
               last_edge_time_in = item_ff.now_ms;
               last_interval_in  = in_time ? gap[15:0] : 16'd0;
               ring_index_in     = wrap ? '0 : (wr_idx + 1'b1);
               ring_full_in      = wrap || (in_time && ring_full_ff);
            end else if (idle_gap) begin
               last_interval_in = 16'd0;
               ring_index_in    = '0;
               ring_full_in     = 1'b0;
            end
            state_in = S_RD_A;
         end
         S_RD_A: begin
            product_in = mul_a * mul_b;
            state_in   = S_RD_B;
         end
         S_RD_B: begin
            newest_in = rd_data;
            state_in  = S_SPAN;
         end
         S_SPAN: begin
            span_in  = newest_ff - rd_data;
            state_in = S_AVG;
         end
         S_AVG: begin
            if (avg_ok) begin
               div_req.start = 1'b1;
               state_in      = S_AVG_WAIT;
            end else begin
               avg_in   = 16'd0;
               state_in = S_SPD;
            end
         end
         S_AVG_WAIT: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient;
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            div_req.num = {16'b0, speed_scale_ff};
            div_req.den = {16'b0, last_interval_ff};
            if (last_interval_ff != 16'd0) begin
               div_req.start = 1'b1;
               state_in      = S_SPD_WAIT;
            end else begin
               speed_in = 16'd0;
               state_in = S_SQR;
            end
         end
         S_SPD_WAIT: begin
            if (div_rsp.done) begin
               speed_in = div_rsp.quotient;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            product_in = mul_a * mul_b;
            state_in   = S_BRK;
         end
         S_BRK: begin
            div_req.den = {16'b0, brake_den};
            if (speed_ff != 16'd0) begin
               div_req.start = 1'b1;
               state_in      = S_BRK_WAIT;
            end else begin
               brake_in = 16'd0;
               state_in = S_DIST;
            end
         end
         S_BRK_WAIT: begin
            if (div_rsp.done) begin
               brake_in = div_rsp.quotient;
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            product_in = mul_a * mul_b;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output register frees itself on a transfer and is refilled from
   // the final state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in                    = 1'b1;
         rsp_data_in.edge_accepted       = accepted_ff;
         rsp_data_in.speed_cm_s          = speed_ff;
         rsp_data_in.average_speed_cm_s  = avg_ff;
         rsp_data_in.average_full        = ring_full_ff;
         rsp_data_in.distance_mm         = (product_ff[31:16] != 16'd0) ?
                                           esm_pkg::SAT16 : product_ff[15:0];
         rsp_data_in.braking_distance_mm = brake_ff;
         rsp_data_in.total_count         = count_total_ff;
         rsp_data_in.ride_count          = count_ride_ff;
      end
   end

   // Configuration writes land whenever the enable is high; unknown indexes
   // are dropped.
   always_comb begin
      ring_window_in  = ring_window_ff;
      timeout_in      = timeout_ff;
      speed_scale_in  = speed_scale_ff;
      mm_per_count_in = mm_per_count_ff;
      braking_div_in  = braking_div_ff;
      if (csr_we) begin
         case (csr_index)
            esm_pkg::CSR_RING_WINDOW:     ring_window_in  = csr_data[7:0];
            esm_pkg::CSR_TIMEOUT:         timeout_in      = csr_data;
            esm_pkg::CSR_SPEED_SCALE:     speed_scale_in  = csr_data;
            esm_pkg::CSR_MM_PER_COUNT:    mm_per_count_in = csr_data[7:0];
            esm_pkg::CSR_BRAKING_DIVISOR: braking_div_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         ring_window_ff    <= esm_pkg::RESET_RING_WINDOW;
         timeout_ff        <= esm_pkg::RESET_TIMEOUT;
         speed_scale_ff    <= esm_pkg::RESET_SPEED_SCALE;
         mm_per_count_ff   <= esm_pkg::RESET_MM_PER_COUNT;
         braking_div_ff    <= esm_pkg::RESET_BRAKING_DIVISOR;
         last_edge_time_ff <= '0;
         last_interval_ff  <= '0;
         ring_index_ff     <= '0;
         ring_full_ff      <= 1'b0;
         count_total_ff    <= '0;
         count_ride_ff     <= '0;
         accepted_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         ring_window_ff    <= ring_window_in;
         timeout_ff        <= timeout_in;
         speed_scale_ff    <= speed_scale_in;
         mm_per_count_ff   <= mm_per_count_in;
         braking_div_ff    <= braking_div_in;
         last_edge_time_ff <= last_edge_time_in;
         last_interval_ff  <= last_interval_in;
         ring_index_ff     <= ring_index_in;
         ring_full_ff      <= ring_full_in;
         count_total_ff    <= count_total_in;
         count_ride_ff     <= count_ride_in;
         accepted_ff       <= accepted_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      product_ff  <= product_in;
      newest_ff   <= newest_in;
      span_ff     <= span_in;
      avg_ff      <= avg_in;
      speed_ff    <= speed_in;
      brake_ff    <= brake_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Time stamp ring. Only slots written since the last restart are ever
   // read, so reset need not clear it.
   esm_ram #(
      .WIDTH  (32),
      .DEPTH  (RING_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   ((state_ff == S_EDGE) && edge_ok),
      .wr_addr (wr_idx),
      .wr_data (item_ff.now_ms),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   esm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider only reports a result while the sequencer waits for one.
   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> ((state_ff == S_AVG_WAIT) || (state_ff == S_SPD_WAIT) ||
                        (state_ff == S_BRK_WAIT)))
      else $error("divider result arrived outside a wait state");

   // The write pointer never leaves the ring.
   a_ring_index_range : assert property (@(posedge clock) disable iff (reset)
      ring_index_ff <= LAST_IDX)
      else $error("ring index beyond ring depth");

   // After an accepted edge the ring holds at least one stamp.
   a_ring_not_empty : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RD_A) && accepted_ff) |-> (ring_full_ff || (ring_index_ff != '0)))
      else $error("accepted edge left the ring empty");

   // The divider never reports a result straight after a start.
   a_div_start_waits : assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.done)
      else $error("divider finished straight after a start");

endmodule

`default_nettype wire

FILE: rtl/esm_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module esm_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 21,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/esm_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The first step tests the
// overflow bit; once it is set the result saturates to all ones.
module esm_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire esm_pkg::div_req_type div_req,
   output esm_pkg::div_rsp_type      div_rsp
);

   localparam logic [esm_pkg::DIV_STEP_W-1:0] LAST_STEP =
      esm_pkg::DIV_STEP_W'(esm_pkg::DIV_STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [esm_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [47:0]                   dsh_ff, dsh_in;
   logic [16:0]                   quo_ff, quo_in;
   logic                          fits;

   assign fits = ({16'b0, rem_ff} >= dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = div_req.num;
         dsh_in  = {div_req.den, 16'b0};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? (rem_ff - dsh_ff[31:0]) : rem_ff;
         quo_in  = {quo_ff[15:0], fits};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[16] ? esm_pkg::SAT16 : quo_ff[15:0];

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Depth of the time stamp ring in the block as instantiated below.
   localparam int RING_DEPTH = esm_pkg::DEFAULT_RING_DEPTH;

   // This many quiet cycles after the last result leave the block certainly idle before a
   // register is written.
   localparam int SETTLE_CYCLES = 80;

   // Cycles without any transfer on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 20000;

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 170;
   localparam int RING_LAPS_EDGES = 300;

   // All block inputs start at known values; they are then driven with
   // nonblocking assignments at the rising clock edge only.
   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   esm_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   esm_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [esm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [esm_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   // When set, neither the sender nor the receiver idles.
   logic steady = 1'b0;

   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   int unsigned stall_run      = 0;
   int unsigned items_sent     = 0;

   // Millisecond time of the most recent intended encoder edge.
   logic [31:0] sim_ms = '0;

   // Readings predicted for accepted items, oldest first.
   esm_pkg::rsp_type expected_readings[$];

   // Own copy of the configuration registers, updated as they are written.
   logic [7:0]  cfg_ring_window     = esm_pkg::RESET_RING_WINDOW;
   logic [15:0] cfg_timeout         = esm_pkg::RESET_TIMEOUT;
   logic [15:0] cfg_speed_scale     = esm_pkg::RESET_SPEED_SCALE;
   logic [7:0]  cfg_mm_per_count    = esm_pkg::RESET_MM_PER_COUNT;
   logic [15:0] cfg_braking_divisor = esm_pkg::RESET_BRAKING_DIVISOR;

   // Own copy of the measurement state.
   logic [31:0] edge_stamp_last = '0;
   logic [15:0] interval_ms     = '0;
   logic [31:0] stamp_ring [RING_DEPTH];
   int unsigned ring_slot       = 0;
   logic        ring_wrapped    = 1'b0;
   logic [15:0] edges_total     = '0;
   logic [15:0] edges_ride      = '0;

   encoder_speed_meter_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] saturate16(logic [63:0] value);
      return (value > 64'(esm_pkg::SAT16)) ? esm_pkg::SAT16 : value[15:0];
   endfunction

   // Forgets the interval and the ring; the edge time and the counts are kept.
   function automatic void clear_motion_state();
      interval_ms  = '0;
      ring_slot    = 0;
      ring_wrapped = 1'b0;
      foreach (stamp_ring[i]) stamp_ring[i] = '0;
   endfunction

   // Advances the predicted state by one item and returns the reading it yields.
   function automatic esm_pkg::rsp_type compute_reading(esm_pkg::req_type item);
      esm_pkg::rsp_type reading;
      logic [31:0] gap;
      logic [31:0] span;
      logic [63:0] numer;
      logic [15:0] speed;
      logic [15:0] divisor;
      int unsigned slot;
      int unsigned newest;
      reading = '0;
      speed   = '0;
      if (item.clear_counts) begin
         edges_total = '0;
         edges_ride  = '0;
      end
      if (item.edge_req) begin
         gap = item.now_ms - edge_stamp_last;
         // Edges no further than the ringing window from the last one are dropped.
         if (gap > 32'(cfg_ring_window)) begin
            slot = ring_slot;
            reading.edge_accepted = 1'b1;
            edge_stamp_last = item.now_ms;
            if (gap < 32'(cfg_timeout)) begin
               interval_ms = gap[15:0];
            end else begin
               // A gap that reached the timeout restarts the ring from its first slot.
               interval_ms  = '0;
               slot         = 0;
               ring_wrapped = 1'b0;
            end
            stamp_ring[slot] = item.now_ms;
            slot++;
            if (slot >= RING_DEPTH) begin
               slot         = 0;
               ring_wrapped = 1'b1;
            end
            ring_slot = slot;
            edges_total++;
            edges_ride++;
         end
      end
      if (item.now_ms - edge_stamp_last > esm_pkg::IDLE_LIMIT_MS) begin
         clear_motion_state();
      end else begin
         span  = '0;
         numer = '0;
         if (!ring_wrapped) begin
            // Partial ring: average over the stamps written so far.
            if (ring_slot >= 2) begin
               span  = stamp_ring[ring_slot - 1] - stamp_ring[0];
               numer = 64'(cfg_speed_scale) * 64'(ring_slot - 1);
            end
         end else begin
            // Full ring: newest stamp against the oldest, which sits at the next slot.
            newest = (ring_slot == 0) ? RING_DEPTH - 1 : ring_slot - 1;
            span   = stamp_ring[newest] - stamp_ring[ring_slot];
            numer  = 64'(cfg_speed_scale) * 64'(RING_DEPTH - 1);
         end
         if (span != 0) reading.average_speed_cm_s = saturate16(numer / 64'(span));
      end
      if (interval_ms != 0) speed = cfg_speed_scale / interval_ms;
      // A braking divisor of zero behaves as one.
      divisor = (cfg_braking_divisor == 0) ? 16'd1 : cfg_braking_divisor;
      reading.speed_cm_s          = speed;
      reading.average_full        = ring_wrapped;
      reading.distance_mm         = saturate16(64'(edges_ride) * 64'(cfg_mm_per_count));
      reading.braking_distance_mm = saturate16(64'(speed) * 64'(speed) / 64'(divisor));
      reading.total_count         = edges_total;
      reading.ride_count          = edges_ride;
      return reading;
   endfunction

   // Mostly no pause at all, often a short one and now and then a long one.
   function automatic int unsigned pause_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 16);
      return $urandom_range(40, 150);
   endfunction

   // Picks a register value: one of the two extremes or something in between.
   function automatic logic [15:0] pick_setting(int unsigned lo, int unsigned hi,
                                               int unsigned mid_lo, int unsigned mid_hi);
      case ($urandom_range(0, 3))
         0:       return lo[15:0];
         1:       return hi[15:0];
         default: return 16'($urandom_range(mid_lo, mid_hi));
      endcase
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Offers one item, waits for its transfer, records the predicted reading and
   // then lets the sender idle for a random number of cycles. Unless it pauses, the valid
   // is left high after a transfer so that back-to-back items need no second assignment.
   task automatic send_item(input logic [31:0] now, input logic edge_bit,
                            input logic clear_bit);
      esm_pkg::req_type item;
      int unsigned      pause;
      item.now_ms       = now;
      item.edge_req     = edge_bit;
      item.clear_counts = clear_bit;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_readings.push_back(compute_reading(item));
      items_sent++;
      pause = steady ? 0 : pause_length();
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   // The sender holds back until every predicted reading has been received.
   // At least one edge passes, so the next item is offered in a later time step.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the enable is left high for a following write.
   task automatic write_register(input logic [esm_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [esm_pkg::CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      case (index)
         esm_pkg::CSR_RING_WINDOW:     cfg_ring_window     = value[7:0];
         esm_pkg::CSR_TIMEOUT:         cfg_timeout         = value;
         esm_pkg::CSR_SPEED_SCALE:     cfg_speed_scale     = value;
         esm_pkg::CSR_MM_PER_COUNT:    cfg_mm_per_count    = value[7:0];
         esm_pkg::CSR_BRAKING_DIVISOR: cfg_braking_divisor = value;
         default:                      ;
      endcase
   endtask

   // Brings the block to rest and then rewrites all five registers.
   task automatic configure(input logic [15:0] ring_window, input logic [15:0] timeout,
                            input logic [15:0] scale, input logic [15:0] mm_per_count,
                            input logic [15:0] braking_divisor);
      settle();
      write_register(esm_pkg::CSR_RING_WINDOW, ring_window);
      write_register(esm_pkg::CSR_TIMEOUT, timeout);
      write_register(esm_pkg::CSR_SPEED_SCALE, scale);
      write_register(esm_pkg::CSR_MM_PER_COUNT, mm_per_count);
      write_register(esm_pkg::CSR_BRAKING_DIVISOR, braking_divisor);
      csr_we <= 1'b0;
   endtask

   // A run of encoder edges, mostly at plausible spacing with items between them,
   // sprinkled with ringing, timed-out gaps, idle spells, time jumps and clears.
   task automatic ride_sequence(input int unsigned edges);
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      logic [31:0] gap;
      logic        clear_bit;
      for (int n = 0; n < edges; n++) begin
         pick      = $urandom_range(0, 99);
         clear_bit = ($urandom_range(0, 39) == 0);
         if (pick < 90) begin
            lo = 32'(cfg_ring_window) + 1;
            hi = (cfg_timeout > 16'd901) ? 900 : 32'(cfg_timeout) - 1;
            if (hi < lo) hi = lo + 100;
            gap = $urandom_range(lo, hi);
         end else if (pick < 94) begin
            // Ringing: this edge must be dropped, so the edge time does not move.
            send_item(sim_ms + $urandom_range(0, cfg_ring_window), 1'b1, clear_bit);
            continue;
         end else if (pick < 96) begin
            gap = 32'(cfg_timeout) + $urandom_range(0, 50);
         end else if (pick < 98) begin
            gap = $urandom_range(esm_pkg::IDLE_LIMIT_MS + 1, 4000);
         end else begin
            gap = $urandom;
         end
         repeat ($urandom_range(0, 2))
            send_item(sim_ms + $urandom_range(0, gap), 1'b0, ($urandom_range(0, 39) == 0));
         sim_ms += gap;
         send_item(sim_ms, 1'b1, clear_bit);
      end
   endtask

   // Register defaults after reset: ringing, the wrap of the millisecond time,
   // the timeout and idle boundaries and a clear on a dropped edge.
   task automatic test_reset_defaults();
      send_item(32'd0, 1'b1, 1'b0);          // no time has passed since reset
      send_item(32'hFFFF_FFFF, 1'b1, 1'b0);  // enormous gap, so no interval
      send_item(32'd4, 1'b1, 1'b0);          // the time wraps; gap of five
      send_item(32'd5, 1'b1, 1'b0);
      send_item(32'd6, 1'b1, 1'b1);          // dropped edge that also clears the counts
      send_item(32'd10, 1'b1, 1'b0);
      send_item(32'd12, 1'b0, 1'b0);
      send_item(32'd209, 1'b1, 1'b0);        // just inside the timeout
      send_item(32'd409, 1'b1, 1'b0);        // exactly at the timeout
      send_item(32'd412, 1'b1, 1'b0);        // exactly at the ringing window
      send_item(32'd413, 1'b1, 1'b0);
      send_item(32'd1413, 1'b0, 1'b0);       // exactly the idle limit
      send_item(32'd1414, 1'b0, 1'b0);       // just past it
      send_item(32'd1420, 1'b1, 1'b0);
      send_item(32'd1425, 1'b1, 1'b0);
   endtask

   // Registers at their extremes, a zero braking divisor, upper bits on the
   // byte-wide registers and writes to indexes that hold no register.
   task automatic test_register_extremes();
      logic [31:0] base;
      base = 32'h8000_0000;
      configure(16'd0, 16'hFFFF, 16'hFFFF, 16'd255, 16'd0);
      send_item(base, 1'b1, 1'b0);
      send_item(base + 1, 1'b1, 1'b0);       // fastest speed, braking saturates
      send_item(base + 2, 1'b1, 1'b0);
      send_item(base + 2, 1'b1, 1'b0);       // no gap at all is still ringing
      settle();
      for (int idx = esm_pkg::CSR_BRAKING_DIVISOR + 1; idx < 2 ** esm_pkg::CSR_INDEX_W;
           idx++)
         write_register(esm_pkg::CSR_INDEX_W'(idx), 16'($urandom));
      csr_we <= 1'b0;
      send_item(base + 3, 1'b1, 1'b0);
      configure({8'hA5, 8'hFF}, 16'd1, 16'd1, {8'h5A, 8'h01}, 16'hFFFF);
      send_item(base + 300, 1'b1, 1'b0);
      send_item(base + 555, 1'b1, 1'b0);     // at the widest ringing window
      send_item(base + 556, 1'b1, 1'b0);
      configure(16'd255, 16'hFFFF, 16'd1, 16'd1, 16'd1);
      send_item(base + 900, 1'b1, 1'b0);
      send_item(base + 1200, 1'b1, 1'b0);
   endtask

   // A long ride with no clear and no idling: the ring wraps many times and the
   // distance saturates at the largest millimetres per count.
   task automatic test_ring_laps();
      steady = 1'b1;
      configure(16'd2, 16'd500, 16'($urandom_range(1, 65535)), 16'd255, 16'd70);
      sim_ms = $urandom;
      send_item(sim_ms, 1'b1, 1'b0);
      for (int n = 0; n < RING_LAPS_EDGES; n++) begin
         sim_ms += $urandom_range(3, 60);
         if ($urandom_range(0, 9) == 0) send_item(sim_ms - 1, 1'b0, 1'b0);
         send_item(sim_ms, 1'b1, 1'b0);
      end
      steady = 1'b0;
   endtask

   // Random rides under a fresh random setting in each phase. Every phase holds
   // the sender back at least once until all readings have come.
   task automatic test_random_rides();
      int unsigned phase_start;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure({8'($urandom), 8'(pick_setting(0, 255, 1, 12))},
                   pick_setting(1, 65535, 30, 1200),
                   pick_setting(1, 65535, 1, 65535),
                   {8'($urandom), 8'(pick_setting(1, 255, 1, 255))},
                   pick_setting(1, 65535, 1, 65535));
         sim_ms      = $urandom;
         phase_start = items_sent;
         ride_sequence($urandom_range(5, 40));
         drain();
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            ride_sequence($urandom_range(5, 40));
            if ($urandom_range(0, 7) == 0) drain();
         end
      end
   endtask

   // The receiver stalls in runs of random length, or never in steady stretches.
   always @(posedge clock) begin
      if (steady) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run = pause_length() + 1;
      end
   end

   // Every result transfer is compared with the oldest predicted reading.
   always @(posedge clock) begin : check_readings
      esm_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_readings.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected nothing, actual %p", $time, rsp_data);
         end else begin
            want = expected_readings.pop_front();
            check_field("edge_accepted", 16'(want.edge_accepted),
                        16'(rsp_data.edge_accepted));
            check_field("speed_cm_s", want.speed_cm_s, rsp_data.speed_cm_s);
            check_field("average_speed_cm_s", want.average_speed_cm_s,
                        rsp_data.average_speed_cm_s);
            check_field("average_full", 16'(want.average_full),
                        16'(rsp_data.average_full));
            check_field("distance_mm", want.distance_mm, rsp_data.distance_mm);
            check_field("braking_distance_mm", want.braking_distance_mm,
                        rsp_data.braking_distance_mm);
            check_field("total_count", want.total_count, rsp_data.total_count);
            check_field("ride_count", want.ride_count, rsp_data.ride_count);
         end
      end
   end

   // The watchdog restarts its count on any transfer in either direction.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      clear_motion_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_ring_laps();
      test_random_rides();

      // Wait for the last readings, then give the block time to show anything extra.
      settle();
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
